>>> design/acbm_pkg.sv
// shared types, constants and codes of the ambient to backlight curve mapper
// no dependencies; used by every other file of the block
package acbm_pkg;

    localparam int MAX_POINTS  = 8;
    localparam int NUM_SEG     = MAX_POINTS - 1;
    localparam int LVL_W       = 7;
    localparam int PT_W        = 2 * LVL_W;
    localparam int CNT_W       = 4;
    localparam int CFG_W       = 56;
    localparam int CFG_IDX_W   = 3;
    localparam int PATH_W      = 3;
    localparam int QUO_W       = LVL_W;
    localparam int PROD_W      = 2 * LVL_W;
    localparam int SUM_W       = LVL_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LVL_W-1:0] PCT_MAX = 7'd100;

    typedef logic [PATH_W-1:0] t_path;

    localparam t_path PATH_LINEAR     = 3'd0;
    localparam t_path PATH_DEGENERATE = 3'd1;
    localparam t_path PATH_SEGMENT    = 3'd2;
    localparam t_path PATH_DUPLICATE  = 3'd3;
    localparam t_path PATH_BELOW      = 3'd4;
    localparam t_path PATH_BEYOND     = 3'd5;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_USE_CURVE   = 3'd0;
    localparam t_reg_idx REG_POINT_COUNT = 3'd1;
    localparam t_reg_idx REG_POINTS_LO   = 3'd2;
    localparam t_reg_idx REG_POINTS_HI   = 3'd3;
    localparam t_reg_idx REG_CAM_FLOOR   = 3'd4;
    localparam t_reg_idx REG_CAM_CEIL    = 3'd5;
    localparam t_reg_idx REG_SCR_FLOOR   = 3'd6;
    localparam t_reg_idx REG_SCR_CEIL    = 3'd7;

    typedef struct packed {
        logic                 use_curve;
        logic [CNT_W-1:0]     point_count;
        logic [2*CFG_W-1:0]   points;
        logic [LVL_W-1:0]     cam_floor;
        logic [LVL_W-1:0]     cam_ceil;
        logic [LVL_W-1:0]     scr_floor;
        logic [LVL_W-1:0]     scr_ceil;
    } t_cfg;

    // classified item: result = base + trunc(a * dy / d)
    typedef struct packed {
        logic [LVL_W-1:0] a;
        logic [LVL_W:0]   dy;
        logic [LVL_W-1:0] d;
        logic [LVL_W-1:0] base;
        t_path            path;
    } t_job;

    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  q;
        logic [LVL_W-1:0]  d;
        logic [LVL_W-1:0]  base;
        t_path             path;
        logic              neg;
    } t_div;

endpackage

>>> design/acbm_in_if.sv
// input channel of the curve mapper: one ambient level per item
// depends on acbm_pkg
interface acbm_in_if;
    logic                        valid;
    logic                        ready;
    logic [acbm_pkg::LVL_W-1:0]  ambient_level;

    modport source (output valid, output ambient_level, input ready);
    modport sink (input valid, input ambient_level, output ready);
endinterface

>>> design/acbm_out_if.sv
// output channel of the curve mapper: screen level and path code per item
// depends on acbm_pkg
interface acbm_out_if;
    logic                        valid;
    logic                        ready;
    logic [acbm_pkg::LVL_W-1:0]  screen_level;
    acbm_pkg::t_path             path_taken;

    modport source (output valid, output screen_level, output path_taken, input ready);
    modport sink (input valid, input screen_level, input path_taken, output ready);
endinterface

>>> design/acbm_front.sv
// front part: accepts ambient levels, picks the segment or linear range
// and registers the interpolation operands; depends on acbm_pkg, acbm_in_if
module acbm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  acbm_pkg::t_cfg    i_cfg,
    acbm_in_if.sink           i_in,
    output logic              o_valid,
    input  logic              i_ready,
    output acbm_pkg::t_job    o_job
);

    logic                         r_valid;
    acbm_pkg::t_job               r_job;
    acbm_pkg::t_job               n_job;

    logic [acbm_pkg::LVL_W-1:0]   lvl;
    logic [acbm_pkg::CNT_W-1:0]   cnt;
    logic [acbm_pkg::LVL_W-1:0]   px [acbm_pkg::MAX_POINTS];
    logic [acbm_pkg::LVL_W-1:0]   py [acbm_pkg::MAX_POINTS];
    logic [acbm_pkg::NUM_SEG-1:0] hit;
    logic                         found;
    logic [acbm_pkg::LVL_W-1:0]   sx0, sx1, sy0, sy1, ylast;
    logic [acbm_pkg::LVL_W-1:0]   c1, c2;
    logic                         curve;

    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_job      = r_job;

    always_comb begin
        lvl = i_in.ambient_level;
        cnt = (i_cfg.point_count > 4'(acbm_pkg::MAX_POINTS)) ?
              4'(acbm_pkg::MAX_POINTS) : i_cfg.point_count;
        curve = i_cfg.use_curve && (cnt >= 4'd2);
        for (int k = 0; k < acbm_pkg::MAX_POINTS; k++) begin
            px[k] = i_cfg.points[acbm_pkg::PT_W*k +: acbm_pkg::LVL_W];
            py[k] = i_cfg.points[acbm_pkg::PT_W*k + acbm_pkg::LVL_W +: acbm_pkg::LVL_W];
        end
        for (int k = 0; k < acbm_pkg::NUM_SEG; k++) begin
            hit[k] = (4'(k + 1) < cnt) && (lvl >= px[k]) && (lvl <= px[k+1]);
        end
        // first stored segment wins
        found = 1'b0;
        sx0   = '0;
        sx1   = '0;
        sy0   = '0;
        sy1   = '0;
        for (int k = acbm_pkg::NUM_SEG - 1; k >= 0; k--) begin
            if (hit[k]) begin
                found = 1'b1;
                sx0   = px[k];
                sx1   = px[k+1];
                sy0   = py[k];
                sy1   = py[k+1];
            end
        end
        ylast = py[0];
        for (int k = 0; k < acbm_pkg::MAX_POINTS; k++) begin
            if (4'(k + 1) == cnt) begin
                ylast = py[k];
            end
        end
        c1 = (lvl > i_cfg.cam_ceil) ? i_cfg.cam_ceil : lvl;
        c2 = (c1 < i_cfg.cam_floor) ? i_cfg.cam_floor : c1;

        n_job.a    = '0;
        n_job.dy   = '0;
        n_job.d    = 7'd1;
        n_job.base = '0;
        n_job.path = acbm_pkg::PATH_LINEAR;
        if (curve) begin
            if (found) begin
                if (sx0 == sx1) begin
                    n_job.base = sy1;
                    n_job.path = acbm_pkg::PATH_DUPLICATE;
                end else begin
                    n_job.a    = lvl - sx0;
                    n_job.d    = sx1 - sx0;
                    n_job.dy   = {1'b0, sy1} - {1'b0, sy0};
                    n_job.base = sy0;
                    n_job.path = acbm_pkg::PATH_SEGMENT;
                end
            end else if (lvl < px[0]) begin
                n_job.base = py[0];
                n_job.path = acbm_pkg::PATH_BELOW;
            end else begin
                n_job.base = ylast;
                n_job.path = acbm_pkg::PATH_BEYOND;
            end
        end else if (i_cfg.cam_ceil == i_cfg.cam_floor) begin
            n_job.base = i_cfg.scr_floor;
            n_job.path = acbm_pkg::PATH_DEGENERATE;
        end else begin
            n_job.a    = c2 - i_cfg.cam_floor;
            n_job.d    = (i_cfg.cam_ceil > i_cfg.cam_floor) ?
                         (i_cfg.cam_ceil - i_cfg.cam_floor) :
                         (i_cfg.cam_floor - i_cfg.cam_ceil);
            n_job.dy   = {1'b0, i_cfg.scr_ceil} - {1'b0, i_cfg.scr_floor};
            n_job.base = i_cfg.scr_floor;
            n_job.path = acbm_pkg::PATH_LINEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_job <= n_job;
        end
    end

endmodule

>>> design/acbm_queue.sv
// short queue between the classifying front and the arithmetic back
// depends on acbm_pkg
module acbm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  acbm_pkg::t_job    i_job,
    output logic              o_valid,
    input  logic              i_ready,
    output acbm_pkg::t_job    o_job
);

    acbm_pkg::t_job                    r_mem [acbm_pkg::QUEUE_DEPTH];
    logic [acbm_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr;
    logic [acbm_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr;
    logic [acbm_pkg::QUEUE_CNT_W-1:0]  r_count;
    logic                              push, pop;

    assign o_ready = (r_count != acbm_pkg::QUEUE_CNT_W'(acbm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == acbm_pkg::QUEUE_PTR_W'(acbm_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == acbm_pkg::QUEUE_PTR_W'(acbm_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> design/acbm_back.sv
// back part: multiply, pipelined restoring divide, offset and clamp,
// output register; depends on acbm_pkg, acbm_out_if
module acbm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  acbm_pkg::t_job    i_job,
    acbm_out_if.source        o_out
);

    logic                          r_v  [acbm_pkg::QUO_W+1];
    acbm_pkg::t_div                r_st [acbm_pkg::QUO_W+1];
    acbm_pkg::t_div                n_st [acbm_pkg::QUO_W+1];
    logic                          r_out_v;
    logic [acbm_pkg::LVL_W-1:0]    r_out_lvl;
    acbm_pkg::t_path               r_out_path;
    logic [acbm_pkg::LVL_W-1:0]    n_out_lvl;
    logic                          en;
    logic [acbm_pkg::LVL_W:0]      dy_abs;
    logic [acbm_pkg::PROD_W-1:0]   shifted [acbm_pkg::QUO_W];
    logic [acbm_pkg::SUM_W-1:0]    qx, sum;
    acbm_pkg::t_div                last;

    assign en           = !r_out_v || o_out.ready;
    assign o_ready      = en;
    assign o_out.valid        = r_out_v;
    assign o_out.screen_level = r_out_lvl;
    assign o_out.path_taken   = r_out_path;

    always_comb begin
        dy_abs = i_job.dy[acbm_pkg::LVL_W] ? (~i_job.dy + 1'b1) : i_job.dy;
        n_st[0].rem  = i_job.a * dy_abs[acbm_pkg::LVL_W-1:0];
        n_st[0].q    = '0;
        n_st[0].d    = i_job.d;
        n_st[0].base = i_job.base;
        n_st[0].path = i_job.path;
        n_st[0].neg  = i_job.dy[acbm_pkg::LVL_W];
        // quotient never exceeds 7 bits since a <= d
        for (int j = 0; j < acbm_pkg::QUO_W; j++) begin
            shifted[j] = acbm_pkg::PROD_W'(r_st[j].d) << (acbm_pkg::QUO_W - 1 - j);
            n_st[j+1]  = r_st[j];
            if (r_st[j].rem >= shifted[j]) begin
                n_st[j+1].rem = r_st[j].rem - shifted[j];
                n_st[j+1].q[acbm_pkg::QUO_W-1-j] = 1'b1;
            end
        end
        last = r_st[acbm_pkg::QUO_W];
        qx   = {2'b00, last.q};
        sum  = {2'b00, last.base} + (last.neg ? (~qx + 1'b1) : qx);
        n_out_lvl = last.base;
        if (last.path == acbm_pkg::PATH_LINEAR || last.path == acbm_pkg::PATH_SEGMENT) begin
            if (sum[acbm_pkg::SUM_W-1]) begin
                n_out_lvl = '0;
            end else if (sum[acbm_pkg::SUM_W-2:0] > {1'b0, acbm_pkg::PCT_MAX}) begin
                n_out_lvl = acbm_pkg::PCT_MAX;
            end else begin
                n_out_lvl = sum[acbm_pkg::LVL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= acbm_pkg::QUO_W; j++) begin
                r_v[j] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int j = 0; j < acbm_pkg::QUO_W; j++) begin
                r_v[j+1] <= r_v[j];
            end
            r_out_v <= r_v[acbm_pkg::QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j <= acbm_pkg::QUO_W; j++) begin
                r_st[j] <= n_st[j];
            end
            r_out_lvl  <= n_out_lvl;
            r_out_path <= last.path;
        end
    end

endmodule

>>> design/ambient_to_backlight_curve_map.sv
// Maps an ambient level to a backlight percentage, by a curve of up to eight
// stored points or by a linear range map. One level is taken per clock while
// the output is not held off. Each level passes the front register, the queue,
// the product register and the restoring divider stages (one quotient bit per
// stage), after which the output register holds it. A held-off result stalls
// the whole back part; the two-entry queue and the front register then fill
// and the input stalls. Write the configuration registers only while no item
// is in flight.
module ambient_to_backlight_curve_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  acbm_pkg::t_reg_idx              i_cfg_idx,
    input  logic [acbm_pkg::CFG_W-1:0]      i_cfg_data,
    acbm_in_if.sink                         i_in,
    acbm_out_if.source                      o_out
);

    logic                              r_use_curve;
    logic [acbm_pkg::CNT_W-1:0]        r_point_count;
    logic [acbm_pkg::CFG_W-1:0]        r_points_lo;
    logic [acbm_pkg::CFG_W-1:0]        r_points_hi;
    logic [acbm_pkg::LVL_W-1:0]        r_cam_floor;
    logic [acbm_pkg::LVL_W-1:0]        r_cam_ceil;
    logic [acbm_pkg::LVL_W-1:0]        r_scr_floor;
    logic [acbm_pkg::LVL_W-1:0]        r_scr_ceil;
    acbm_pkg::t_cfg                    cfg;

    logic                              f_valid, q_in_ready, q_valid, b_ready;
    acbm_pkg::t_job                    f_job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_curve   <= 1'b0;
            r_point_count <= '0;
            r_points_lo   <= '0;
            r_points_hi   <= '0;
            r_cam_floor   <= '0;
            r_cam_ceil    <= acbm_pkg::PCT_MAX;
            r_scr_floor   <= '0;
            r_scr_ceil    <= acbm_pkg::PCT_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                acbm_pkg::REG_USE_CURVE:   r_use_curve   <= i_cfg_data[0];
                acbm_pkg::REG_POINT_COUNT: r_point_count <= i_cfg_data[acbm_pkg::CNT_W-1:0];
                acbm_pkg::REG_POINTS_LO:   r_points_lo   <= i_cfg_data;
                acbm_pkg::REG_POINTS_HI:   r_points_hi   <= i_cfg_data;
                acbm_pkg::REG_CAM_FLOOR:   r_cam_floor   <= i_cfg_data[acbm_pkg::LVL_W-1:0];
                acbm_pkg::REG_CAM_CEIL:    r_cam_ceil    <= i_cfg_data[acbm_pkg::LVL_W-1:0];
                acbm_pkg::REG_SCR_FLOOR:   r_scr_floor   <= i_cfg_data[acbm_pkg::LVL_W-1:0];
                acbm_pkg::REG_SCR_CEIL:    r_scr_ceil    <= i_cfg_data[acbm_pkg::LVL_W-1:0];
            endcase
        end
    end

    always_comb begin
        cfg.use_curve   = r_use_curve;
        cfg.point_count = r_point_count;
        cfg.points      = {r_points_hi, r_points_lo};
        cfg.cam_floor   = r_cam_floor;
        cfg.cam_ceil    = r_cam_ceil;
        cfg.scr_floor   = r_scr_floor;
        cfg.scr_ceil    = r_scr_ceil;
    end

    acbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (q_in_ready),
        .o_job   (f_job)
    );

    acbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (q_in_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (b_ready),
        .o_job   (q_job)
    );

    acbm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (b_ready),
        .i_job   (q_job),
        .o_out   (o_out)
    );

    a_clamped_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.path_taken == acbm_pkg::PATH_LINEAR ||
                        o_out.path_taken == acbm_pkg::PATH_SEGMENT)
        |-> o_out.screen_level <= acbm_pkg::PCT_MAX)
        else $error("clamped result above full scale");

    a_path_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.path_taken <= acbm_pkg::PATH_BEYOND)
        else $error("path code out of range");

    a_queue_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid && !q_in_ready |=> f_valid && $stable(f_job))
        else $error("front item lost while queue full");

endmodule
